// ===== rtl/etdv_pkg.sv =====
`timescale 1ns / 1ps

package etdv_pkg;

  localparam int PULSE_W = 16;
  localparam int DIST_W  = 10;
  localparam int SUM_W   = 12;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Pulses longer than this cannot come from a finished measurement.
  localparam logic [PULSE_W-1:0] PULSE_LIMIT = 16'd45000;

  // Division by 50 as a multiplication by a rounded-up reciprocal of 2^22 / 50.
  // It is exact over the whole 16-bit pulse range.
  localparam int               DIV50_MUL_W = 17;
  localparam logic [16:0]      DIV50_MUL   = 17'd83887;
  localparam int               DIV50_SHIFT = 22;
  localparam int               QUOT50_W    = 11;

  // Division by 3 as a multiplication by the rounded-up reciprocal of 2^13 / 3.
  // It is exact for every sum of three distances.
  localparam logic [11:0]      DIV3_MUL    = 12'd2731;
  localparam int               DIV3_SHIFT  = 13;

  localparam logic [DIST_W-1:0] MIN_DIST_RESET = 10'd2;

  // Register index, taken from paddr[2] (registers sit on 4-byte spacing).
  localparam logic REG_MIN_DISTANCE = 1'b0;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              accepted;
  } result_t;

endpackage

// ===== rtl/etdv_convert.sv =====
`timescale 1ns / 1ps

module etdv_convert (
  input  logic [etdv_pkg::PULSE_W-1:0] pulse_width,
  input  logic                         timed_out,
  input  logic [etdv_pkg::DIST_W-1:0]  min_distance,
  output logic [etdv_pkg::DIST_W-1:0]  reading,
  output logic                         keep
);
  import etdv_pkg::*;

  localparam int PROD_W = PULSE_W + DIV50_MUL_W;

  logic [PROD_W-1:0]   prod;
  logic [QUOT50_W-1:0] quot;

  assign prod    = PROD_W'(pulse_width) * PROD_W'(DIV50_MUL);
  assign quot    = prod[DIV50_SHIFT +: QUOT50_W];
  assign reading = quot[DIST_W-1:0];

  // An overlong pulse is handled exactly like a timeout.
  assign keep = !timed_out && (pulse_width <= PULSE_LIMIT) &&
                (QUOT50_W'(min_distance) <= quot);

endmodule

// ===== rtl/etdv_triplet.sv =====
`timescale 1ns / 1ps

module etdv_triplet (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [etdv_pkg::DIST_W-1:0] reading,
  output logic                        produces,
  output etdv_pkg::result_t           result
);
  import etdv_pkg::*;

  localparam int PROD_W = SUM_W + SUM_W;
  localparam int TOL_W  = DIST_W + 4;

  logic [1:0]        kept_count;
  logic [DIST_W-1:0] kept_readings [2];
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] mean;
  logic              ok;

  // 10*|mean - reading| <= mean + 10, done with shifts and adds.
  function automatic logic within_tol(logic [DIST_W-1:0] m, logic [DIST_W-1:0] r);
    logic [DIST_W-1:0] diff;
    logic [TOL_W-1:0]  lhs;
    logic [TOL_W-1:0]  rhs;
    diff = (m >= r) ? (m - r) : (r - m);
    lhs  = (TOL_W'(diff) << 3) + (TOL_W'(diff) << 1);
    rhs  = TOL_W'(m) + TOL_W'(10);
    return lhs <= rhs;
  endfunction

  assign produces = (kept_count == 2'd2);

  assign sum  = SUM_W'(kept_readings[0]) + SUM_W'(kept_readings[1]) + SUM_W'(reading);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
  assign mean = prod[DIV3_SHIFT +: DIST_W];
  assign ok   = within_tol(mean, kept_readings[0]) &&
                within_tol(mean, kept_readings[1]) &&
                within_tol(mean, reading);

  always_comb begin
    result.accepted = ok;
    result.distance = ok ? mean : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
    end else if (step) begin
      kept_count <= produces ? 2'd0 : kept_count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !produces) begin
      kept_readings[kept_count[0]] <= reading;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    kept_count != 2'd3)
    else $error("kept count left its range");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && produces |=> kept_count == 2'd0)
    else $error("collection did not restart after a triplet");

  a_rejected_zero: assert property (@(posedge clk) disable iff (rst)
    !result.accepted |-> result.distance == '0)
    else $error("rejected triplet carries a distance");

endmodule

// ===== rtl/echo_triplet_distance_validator.sv =====
`timescale 1ns / 1ps

// A result word is loaded into the result register when the third kept input word,
// already held in the input register, moves on from it. Throughput: one input
// word per cycle while the input is not stalled; discarded readings are accepted
// like kept ones. The result register stalls the input only when a triplet completes
// while a previous result is still waiting. Reset clears the triplet count and sets
// min_distance to 2; the held readings are not cleared.
module echo_triplet_distance_validator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [etdv_pkg::PULSE_W-1:0]  pulse_width,
  input  logic                          timed_out,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [etdv_pkg::DIST_W-1:0]   distance,
  output logic                          accepted,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [etdv_pkg::PADDR_W-1:0]  paddr,
  input  logic [etdv_pkg::PDATA_W-1:0]  pwdata,
  output logic [etdv_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import etdv_pkg::*;

  logic [DIST_W-1:0] min_distance;
  logic [DIST_W-1:0] conv_dist;
  logic              conv_keep;
  logic              s1_valid;
  logic [DIST_W-1:0] s1_dist;
  logic              produces;
  logic              advance;
  result_t           result;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_DISTANCE) ? PDATA_W'(min_distance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance <= MIN_DIST_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == REG_MIN_DISTANCE) begin
      min_distance <= pwdata[DIST_W-1:0];
    end
  end

  etdv_convert u_convert (
    .pulse_width (pulse_width),
    .timed_out   (timed_out),
    .min_distance(min_distance),
    .reading     (conv_dist),
    .keep        (conv_keep)
  );

  // Only kept readings are marked valid in the input register; a held word moves on unless
  // it completes a triplet while the result register is full and stalled.
  assign advance  = s1_valid && (!produces || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= conv_keep;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_dist <= conv_dist;
    end
  end

  etdv_triplet u_triplet (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .reading (s1_dist),
    .produces(produces),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produces) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      distance <= result.distance;
      accepted <= result.accepted;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && produces && out_valid && !out_ready)
    else $error("input stalled without a pending result");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance && produces |=> out_valid)
    else $error("completed triplet did not reach the result register");

  a_out_rejected: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> distance == '0)
    else $error("rejected result word carries a distance");

endmodule
